>>> design/mamst_pkg.sv
`timescale 1ns / 1ps

package mamst_pkg;

    localparam int VAL_W       = 35;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 3;

    localparam logic [1:0] MODE_WR_A = 2'd0;
    localparam logic [1:0] MODE_WR_B = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_TRN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_OP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 3'd3;

    typedef enum logic [1:0] {
        K_WR_A,
        K_WR_B,
        K_RUN
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [15:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] rows_a;
        logic [3:0] cols_a;
        logic [3:0] cols_b;
    } t_cfg;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic       first;
        logic       last_t;
        logic       last;
    } t_meta;

endpackage

>>> design/mamst_ram.sv
`timescale 1ns / 1ps

module mamst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/mamst_front.sv
`timescale 1ns / 1ps

module mamst_front #(
    parameter int MAX_DIM = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_mode,
    input  logic [2:0]          i_row,
    input  logic [2:0]          i_col,
    input  logic signed [15:0]  i_value,
    output logic                o_cmd_valid,
    output mamst_pkg::t_cmd     o_cmd,
    input  logic                i_cmd_pop
);

    import mamst_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    logic  accept;
    logic  keep;
    logic  in_range;
    logic  push;
    t_kind kind;

    assign o_in_stall  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign accept      = i_in_valid && !o_in_stall;
    assign in_range    = (int'(i_row) < MAX_DIM) && (int'(i_col) < MAX_DIM);

    always_comb begin
        kind = K_RUN;
        keep = 1'b0;
        case (i_mode)
            MODE_WR_A: begin
                kind = K_WR_A;
                keep = in_range;
            end
            MODE_WR_B: begin
                kind = K_WR_B;
                keep = in_range;
            end
            MODE_RUN: begin
                kind = K_RUN;
                keep = 1'b1;
            end
            default: begin
                kind = K_RUN;
                keep = 1'b0;
            end
        endcase
    end

    assign push = accept && keep;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_cmd_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!push && i_cmd_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{kind: kind, row: i_row, col: i_col, value: i_value};
        end
    end

    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

endmodule

>>> design/mamst_back.sv
`timescale 1ns / 1ps

module mamst_back #(
    parameter int MAX_DIM       = 8,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mamst_pkg::t_cfg                     i_cfg,
    input  logic                                i_cmd_valid,
    input  mamst_pkg::t_cmd                     i_cmd,
    output logic                                o_cmd_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_out_row,
    output logic [2:0]                          o_out_col,
    output logic signed [mamst_pkg::VAL_W-1:0]  o_out_value,
    output logic                                o_last
);

    import mamst_pkg::*;

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int EW     = ELEMENT_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [1:0]       r_op;
    logic [3:0]       r_nr;
    logic [3:0]       r_nc;
    logic [3:0]       r_nt;
    logic [IDX_W-1:0] r_r;
    logic [IDX_W-1:0] r_c;
    logic [IDX_W-1:0] r_t;
    logic [IDX_W-1:0] n_r;
    logic [IDX_W-1:0] n_c;
    logic [IDX_W-1:0] n_t;

    logic             r_b_vld;
    t_meta            r_b_meta;
    logic [1:0]       r_b_op;
    logic             r_c_vld;
    t_meta            r_c_meta;
    logic [1:0]       r_c_op;
    logic signed [VAL_W-1:0] r_c_val;
    logic signed [VAL_W-1:0] r_acc;
    logic             r_out_vld;
    logic [2:0]       r_out_row;
    logic [2:0]       r_out_col;
    logic signed [VAL_W-1:0] r_out_val;
    logic             r_out_last;

    logic              advance;
    logic              pop;
    logic              issue;
    logic              last_t;
    logic              last_c;
    logic              last_r;
    t_meta             meta;
    logic [ADDR_W-1:0] waddr;
    logic [EW-1:0]     wdata;
    logic signed [31:0] w32;
    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [EW-1:0]     rdata_a;
    logic [EW-1:0]     rdata_b;
    logic signed [EW-1:0]    sa;
    logic signed [EW-1:0]    sb;
    logic signed [VAL_W-1:0] sa_x;
    logic signed [VAL_W-1:0] sb_x;
    logic signed [2*EW-1:0]  prod;
    logic signed [63:0]      prod_x;
    logic signed [VAL_W-1:0] b_val;
    logic signed [VAL_W-1:0] acc_sum;

    assign advance   = !r_out_vld || !i_out_stall;
    assign pop       = i_cmd_valid && (r_state == S_IDLE);
    assign o_cmd_pop = pop;
    assign issue     = (r_state == S_RUN) && advance;

    assign waddr = {i_cmd.row[IDX_W-1:0], i_cmd.col[IDX_W-1:0]};
    assign w32   = 32'(i_cmd.value);
    assign wdata = w32[EW-1:0];
    assign we_a  = pop && (i_cmd.kind == K_WR_A);
    assign we_b  = pop && (i_cmd.kind == K_WR_B);

    assign last_t = (4'(r_t) == r_nt - 4'd1);
    assign last_c = (4'(r_c) == r_nc - 4'd1);
    assign last_r = (4'(r_r) == r_nr - 4'd1);

    always_comb begin
        case (r_op)
            OP_TRN: begin
                raddr_a = {r_c, r_r};
                raddr_b = {r_r, r_c};
            end
            OP_MUL: begin
                raddr_a = {r_r, r_t};
                raddr_b = {r_t, r_c};
            end
            default: begin
                raddr_a = {r_r, r_c};
                raddr_b = {r_r, r_c};
            end
        endcase
    end

    assign meta = '{row: 3'(r_r), col: 3'(r_c), first: (r_t == '0), last_t: last_t,
                    last: last_t && last_c && last_r};

    always_comb begin
        n_state = r_state;
        n_r     = r_r;
        n_c     = r_c;
        n_t     = r_t;
        if (pop && (i_cmd.kind == K_RUN)) begin
            n_state = S_RUN;
            n_r     = '0;
            n_c     = '0;
            n_t     = '0;
        end else if (issue) begin
            if (!last_t) begin
                n_t = r_t + IDX_W'(1);
            end else begin
                n_t = '0;
                if (!last_c) begin
                    n_c = r_c + IDX_W'(1);
                end else begin
                    n_c = '0;
                    if (!last_r) begin
                        n_r = r_r + IDX_W'(1);
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (advance) begin
                r_b_vld   <= issue;
                r_c_vld   <= r_b_vld;
                r_out_vld <= r_c_vld && r_c_meta.last_t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_r <= n_r;
        r_c <= n_c;
        r_t <= n_t;
        if (pop && (i_cmd.kind == K_RUN)) begin
            r_op <= i_cfg.op;
            case (i_cfg.op)
                OP_MUL: begin
                    r_nr <= i_cfg.rows_a;
                    r_nc <= i_cfg.cols_b;
                    r_nt <= i_cfg.cols_a;
                end
                OP_TRN: begin
                    r_nr <= i_cfg.cols_a;
                    r_nc <= i_cfg.rows_a;
                    r_nt <= 4'd1;
                end
                default: begin
                    r_nr <= i_cfg.rows_a;
                    r_nc <= i_cfg.cols_a;
                    r_nt <= 4'd1;
                end
            endcase
        end
    end

    mamst_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (advance),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    mamst_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (advance),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    assign sa     = rdata_a;
    assign sb     = rdata_b;
    assign sa_x   = VAL_W'(sa);
    assign sb_x   = VAL_W'(sb);
    assign prod   = sa * sb;
    assign prod_x = 64'(prod);

    always_comb begin
        case (r_b_op)
            OP_ADD:  b_val = sa_x + sb_x;
            OP_SUB:  b_val = sa_x - sb_x;
            OP_MUL:  b_val = prod_x[VAL_W-1:0];
            default: b_val = sa_x;
        endcase
    end

    assign acc_sum = (r_c_meta.first ? '0 : r_acc) + r_c_val;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b_meta <= meta;
            r_b_op   <= r_op;
            r_c_meta <= r_b_meta;
            r_c_op   <= r_b_op;
            r_c_val  <= b_val;
            if (r_c_vld) begin
                r_acc      <= acc_sum;
                r_out_row  <= r_c_meta.row;
                r_out_col  <= r_c_meta.col;
                r_out_last <= r_c_meta.last;
                r_out_val  <= (r_c_op == OP_MUL) ? acc_sum : r_c_val;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_val;
    assign o_last      = r_out_last;

endmodule

>>> design/matrix_add_sub_mul_transpose.sv
`timescale 1ns / 1ps
// Load transfers are taken one per cycle while o_in_stall is low, queued, and written to matrix
// memory when the back end is idle. A compute transfer is taken from the queue only when idle;
// its results follow one per cycle for add, subtract and transpose while the output is not
// stalled, and for multiply each result sums cols_a products over a row of A and column of B.
// Reset clears control state and sets the registers to add with all sizes one;
// matrix contents are undefined until written.

module matrix_add_sub_mul_transpose #(
    parameter int MAX_DIM       = 8,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_mode,
    input  logic [2:0]                          i_row,
    input  logic [2:0]                          i_col,
    input  logic signed [15:0]                  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_out_row,
    output logic [2:0]                          o_out_col,
    output logic signed [mamst_pkg::VAL_W-1:0]  o_out_value,
    output logic                                o_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mamst_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                         i_cfg_data
);

    import mamst_pkg::*;

    logic [1:0] r_op;
    logic [3:0] r_rows_a;
    logic [3:0] r_cols_a;
    logic [3:0] r_cols_b;
    logic       cfg_we;
    t_cfg       cfg;
    logic       cmd_valid;
    t_cmd       cmd;
    logic       cmd_pop;

    function automatic logic [3:0] dim_sat(input logic [3:0] d);
        logic [3:0] res;
        if (d == 4'd0) begin
            res = 4'd1;
        end else if (int'(d) > MAX_DIM) begin
            res = 4'(MAX_DIM);
        end else begin
            res = d;
        end
        return res;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= OP_ADD;
            r_rows_a <= 4'd1;
            r_cols_a <= 4'd1;
            r_cols_b <= 4'd1;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_OP:     r_op     <= i_cfg_data[1:0];
                CFG_ROWS_A: r_rows_a <= i_cfg_data[3:0];
                CFG_COLS_A: r_cols_a <= i_cfg_data[3:0];
                CFG_COLS_B: r_cols_b <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = '{op: r_op, rows_a: dim_sat(r_rows_a), cols_a: dim_sat(r_cols_a),
                   cols_b: dim_sat(r_cols_b)};

    mamst_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    mamst_back #(
        .MAX_DIM       (MAX_DIM),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mamst_pkg::*;

    localparam int         RANDOM_ITEMS  = 210;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         HOLD_CYCLES   = 200;
    localparam int         CYCLE_LIMIT   = 1000000;
    localparam int         REPORT_LIMIT  = 10;
    localparam logic [1:0] MODE_NONE     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd4;

    typedef struct packed {
        logic [2:0]              row;
        logic [2:0]              col;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_elem;

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_stall;
    logic [1:0]              i_mode      = MODE_WR_A;
    logic [2:0]              i_row       = '0;
    logic [2:0]              i_col       = '0;
    logic signed [15:0]      i_value     = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [2:0]              o_out_row;
    logic [2:0]              o_out_col;
    logic signed [VAL_W-1:0] o_out_value;
    logic                    o_last;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [15:0]             i_cfg_data  = '0;

    matrix_add_sub_mul_transpose i_dut (.*);

    logic signed [15:0] a_elems [8][8];
    logic signed [15:0] b_elems [8][8];
    bit                 a_written [8][8];
    bit                 b_written [8][8];
    logic [1:0]         cur_op     = OP_ADD;
    logic [3:0]         cur_rows_a = 4'd1;
    logic [3:0]         cur_cols_a = 4'd1;
    logic [3:0]         cur_cols_b = 4'd1;
    t_elem              pending_elems [$];

    int          send_idle_pct   = 11;
    int          recv_idle_pct   = 70;
    int unsigned hold_requests   = 0;
    int unsigned hold_seen       = 0;
    int          hold_left       = 0;
    int          errors          = 0;
    int          items_sent      = 0;
    int          results_checked = 0;
    int          configs_written = 0;
    int          cycle_count     = 0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("matrix_add_sub_mul_transpose test failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen   <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_elem want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (pending_elems.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("unexpected result: row %0d col %0d value %0d last %0b",
                             o_out_row, o_out_col, o_out_value, o_last);
                end
            end else begin
                want = pending_elems.pop_front();
                if (o_out_row !== want.row || o_out_col !== want.col ||
                        o_out_value !== want.value || o_last !== want.last) begin
                    errors++;
                    if (errors <= REPORT_LIMIT) begin
                        $display({"mismatch: expected row %0d col %0d value %0d last %0b,",
                                  " got row %0d col %0d value %0d last %0b"},
                                 want.row, want.col, want.value, want.last,
                                 o_out_row, o_out_col, o_out_value, o_last);
                    end
                end
            end
        end
    end

    function automatic int clamp_dim(input logic [3:0] raw);
        if (raw == 4'd0) begin
            return 1;
        end
        if (raw > 4'd8) begin
            return 8;
        end
        return int'(raw);
    endfunction

    function automatic logic signed [15:0] pick_element();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [3:0] pick_dim_raw();
        case ($urandom_range(0, 19))
            0: return 4'd0;
            1: return 4'($urandom_range(9, 15));
            2: return 4'd8;
            default: return 4'($urandom_range(1, 5));
        endcase
    endfunction

    // Walks the result matrix in row-major order and queues one element per position.
    task automatic queue_matrix_result();
        int    ra, ca, cb, nr, nc;
        longint acc;
        t_elem e;
        ra = clamp_dim(cur_rows_a);
        ca = clamp_dim(cur_cols_a);
        cb = clamp_dim(cur_cols_b);
        case (cur_op)
            OP_MUL: begin
                nr = ra;
                nc = cb;
            end
            OP_TRN: begin
                nr = ca;
                nc = ra;
            end
            default: begin
                nr = ra;
                nc = ca;
            end
        endcase
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                case (cur_op)
                    OP_ADD: acc = longint'(a_elems[r][c]) + longint'(b_elems[r][c]);
                    OP_SUB: acc = longint'(a_elems[r][c]) - longint'(b_elems[r][c]);
                    OP_MUL: begin
                        acc = 0;
                        for (int t = 0; t < ca; t++) begin
                            acc += longint'(a_elems[r][t]) * longint'(b_elems[t][c]);
                        end
                    end
                    default: acc = longint'(a_elems[c][r]);
                endcase
                e.row   = 3'(r);
                e.col   = 3'(c);
                e.value = acc[VAL_W-1:0];
                e.last  = (r == nr - 1) && (c == nc - 1);
                pending_elems.push_back(e);
            end
        end
    endtask

    task automatic track_command(input logic [1:0] mode, input logic [2:0] row,
                                 input logic [2:0] col, input logic signed [15:0] value);
        case (mode)
            MODE_WR_A: begin
                a_elems[row][col]   = value;
                a_written[row][col] = 1'b1;
            end
            MODE_WR_B: begin
                b_elems[row][col]   = value;
                b_written[row][col] = 1'b1;
            end
            MODE_RUN: queue_matrix_result();
            default: ;
        endcase
    endtask

    task automatic track_config(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        case (idx)
            CFG_OP:     cur_op     = data[1:0];
            CFG_ROWS_A: cur_rows_a = data[3:0];
            CFG_COLS_A: cur_cols_a = data[3:0];
            CFG_COLS_B: cur_cols_b = data[3:0];
            default: ;
        endcase
    endtask

    // The valid is left high after a transfer; the next call or a drain decides its next value.
    task automatic send_cmd(input logic [1:0] mode, input logic [2:0] row,
                            input logic [2:0] col, input logic signed [15:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_row      <= row;
        i_col      <= col;
        i_value    <= value;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        track_command(mode, row, col, value);
        if (mode != MODE_NONE) begin
            items_sent++;
        end
    endtask

    task automatic send_run();
        send_cmd(MODE_RUN, 3'($urandom), 3'($urandom), 16'($urandom));
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (pending_elems.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [1:0] op, input logic [3:0] ra,
                                input logic [3:0] ca, input logic [3:0] cb,
                                input bit with_unused);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [15:0]          dat [5];
        int                   n;
        idx[0] = CFG_OP;
        dat[0] = {14'($urandom), op};
        idx[1] = CFG_ROWS_A;
        dat[1] = {12'($urandom), ra};
        idx[2] = CFG_COLS_A;
        dat[2] = {12'($urandom), ca};
        idx[3] = CFG_COLS_B;
        dat[3] = {12'($urandom), cb};
        n = 4;
        if (with_unused) begin
            idx[4] = CFG_FIRST_UNUSED + 3'($urandom_range(0, 3));
            dat[4] = 16'($urandom);
            n = 5;
        end
        for (int k = 0; k < n; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= dat[k];
            @(posedge i_clk);
            while (!o_cfg_ready) begin
                @(posedge i_clk);
            end
            track_config(idx[k], dat[k]);
        end
        i_cfg_valid <= 1'b0;
        configs_written++;
    endtask

    // Writes every element of the region that was never written, and rewrites some of the rest.
    task automatic fill_region(input logic [1:0] mode, input int nr, input int nc);
        bit known;
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                known = (mode == MODE_WR_A) ? a_written[r][c] : b_written[r][c];
                if (!known || $urandom_range(0, 3) == 0) begin
                    send_cmd(mode, 3'(r), 3'(c), pick_element());
                end
            end
        end
    endtask

    task automatic run_job();
        logic [1:0] op;
        logic [1:0] noise_mode;
        logic [3:0] ra_raw, ca_raw, cb_raw;
        int         ra, ca, cb;
        op     = 2'($urandom_range(0, 3));
        ra_raw = pick_dim_raw();
        ca_raw = pick_dim_raw();
        cb_raw = pick_dim_raw();
        ra     = clamp_dim(ra_raw);
        ca     = clamp_dim(ca_raw);
        cb     = clamp_dim(cb_raw);
        wait_results_done();
        write_config(op, ra_raw, ca_raw, cb_raw, $urandom_range(0, 9) == 0);
        fill_region(MODE_WR_A, ra, ca);
        if (op == OP_MUL) begin
            fill_region(MODE_WR_B, ca, cb);
        end else if (op != OP_TRN) begin
            fill_region(MODE_WR_B, ra, ca);
        end
        repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 3) == 0) begin
                    noise_mode = MODE_NONE;
                end else begin
                    noise_mode = $urandom_range(0, 1) ? MODE_WR_B : MODE_WR_A;
                end
                send_cmd(noise_mode, 3'($urandom), 3'($urandom), pick_element());
            end
            send_run();
        end
    endtask

    task automatic test_reset_defaults();
        send_cmd(MODE_WR_A, 3'd0, 3'd0, 16'sh7fff);
        send_cmd(MODE_WR_B, 3'd0, 3'd0, 16'sh8000);
        send_run();
        wait_results_done();
        write_config(OP_SUB, 4'd1, 4'd1, 4'd1, 1'b1);
        send_run();
    endtask

    task automatic test_multiply_extremes();
        wait_results_done();
        write_config(OP_MUL, 4'd2, 4'd2, 4'd2, 1'b0);
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 2; c++) begin
                send_cmd(MODE_WR_A, 3'(r), 3'(c), 16'sh8000);
                send_cmd(MODE_WR_B, 3'(r), 3'(c), 16'sh8000);
            end
        end
        send_run();
        send_cmd(MODE_WR_B, 3'd1, 3'd0, 16'sh7fff);
        send_run();
    endtask

    task automatic test_size_saturation();
        wait_results_done();
        write_config(OP_TRN, 4'd0, 4'd15, 4'd0, 1'b1);
        for (int c = 2; c < 8; c++) begin
            send_cmd(MODE_WR_A, 3'd0, 3'(c), pick_element());
        end
        send_cmd(MODE_WR_A, 3'd7, 3'd7, 16'sh7fff);
        send_cmd(MODE_WR_B, 3'd7, 3'd7, 16'shffff);
        send_run();
    endtask

    task automatic test_ignored_mode();
        send_cmd(MODE_NONE, 3'd0, 3'd3, 16'sh1234);
        send_cmd(MODE_NONE, 3'd7, 3'd7, 16'shffff);
        send_run();
    endtask

    task automatic test_output_backpressure();
        int saved_idle;
        wait_results_done();
        write_config(OP_ADD, 4'd3, 4'd3, 4'd1, 1'b0);
        fill_region(MODE_WR_A, 3, 3);
        fill_region(MODE_WR_B, 3, 3);
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        hold_requests++;
        repeat (10) send_run();
        send_idle_pct = saved_idle;
        wait_results_done();
    endtask

    task automatic test_random_jobs();
        int start_count;
        int done;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            done = items_sent - start_count;
            if (done < RANDOM_ITEMS / 3) begin
                send_idle_pct = 11;
                recv_idle_pct = 70;
            end else if (done < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 70;
                recv_idle_pct = 11;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_job();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_multiply_extremes();
        test_size_saturation();
        test_ignored_mode();
        test_output_backpressure();
        test_random_jobs();
        wait_results_done();
        $display("Checked %0d result elements from %0d input transfers",
                 results_checked, items_sent);
        $display("over %0d register settings, covering add, subtract, multiply and %s",
                 configs_written, "transpose under input and output backpressure.");
        if (errors == 0) begin
            $display("matrix_add_sub_mul_transpose test passed");
        end else begin
            $display("matrix_add_sub_mul_transpose test failed");
        end
        $finish;
    end

endmodule
